/* design/wgs_pkg.sv */
// wgs_pkg: shared constants and types for the wave grid stencil step unit
// no dependencies
`timescale 1ns / 1ps

package wgs_pkg;

  localparam int GRID_WIDTH_DEF  = 256;
  localparam int GRID_HEIGHT_DEF = 256;

  localparam int CMD_W   = 2;
  localparam int COORD_W = 8;
  localparam int Q_W     = 24;
  localparam int SPD_W   = 13;

  localparam logic [SPD_W-1:0] SPD_ONE   = 13'd4096;
  localparam logic [SPD_W-1:0] SPD_RESET = 13'd1024;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic clr;       // clearing pass write
    logic host_wr;   // cell write request accepted
    logic rd_latch;  // capture cell address of a read
    logic rd_load;   // load the result register
    logic strm;      // sweep read issued this cycle
    logic ctr_ok;    // sweep index has a center cell
    logic interior;  // that center is in an interior row
  } wgs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } wgs_sts_t;

endpackage

/* design/wgs_ifs.sv */
// wgs_ifs: valid/ready channel interfaces for requests and read results
// depends on wgs_pkg
`timescale 1ns / 1ps

interface wgs_in_if
  import wgs_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [COORD_W-1:0]  cell_x;
  logic [COORD_W-1:0]  cell_y;
  logic signed [Q_W-1:0] write_value;

  modport source (output valid, command, cell_x, cell_y, write_value, input ready);
  modport sink   (input valid, command, cell_x, cell_y, write_value, output ready);
endinterface

interface wgs_out_if
  import wgs_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] displacement;
  logic signed [Q_W-1:0] velocity;

  modport source (output valid, displacement, velocity, input ready);
  modport sink   (input valid, displacement, velocity, output ready);
endinterface

/* design/wave_grid_stencil_step_unit.sv */
// wave_grid_stencil_step_unit: top level of the 2d wave grid stepper
// depends on wgs_pkg, wgs_ifs, wgs_ctrl, wgs_dp
//
//   port      dir   kind            carries
//   in_req    in    valid/ready     command, cell_x, cell_y, write_value
//   out_rsp   out   valid/ready     displacement, velocity (read only)
//   cfg_*     in    write strobe    wave_speed_sq
//
// a write is taken in idle; a read latches the address, issues the ram read, then waits for the result register.
// a step sweeps one cell per cycle through the displacement memory read port, then
// drains the pipeline. after reset a clearing pass zeroes both grids,
// with in_req.ready low; config writes are taken meanwhile.
// a pending result does not block writes or steps; a read waits for it to go.
`timescale 1ns / 1ps

module wave_grid_stencil_step_unit
  import wgs_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  wgs_in_if.sink           in_req,
  wgs_out_if.source        out_rsp,
  input  logic             cfg_we,
  input  logic [SPD_W-1:0] cfg_wdata
);

  localparam int JW = $clog2(GRID_WIDTH * GRID_HEIGHT + GRID_WIDTH);

  wgs_cmd_t      cmd;
  wgs_sts_t      sts;
  logic [JW-1:0] cnt;

  wgs_ctrl #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_command (in_req.command),
    .in_ready   (in_req.ready),
    .sts        (sts),
    .cmd        (cmd),
    .cnt        (cnt)
  );

  wgs_dp #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cnt              (cnt),
    .sts              (sts),
    .in_cell_x        (in_req.cell_x),
    .in_cell_y        (in_req.cell_y),
    .in_write_value   (in_req.write_value),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_ready        (out_rsp.ready),
    .out_valid        (out_rsp.valid),
    .out_displacement (out_rsp.displacement),
    .out_velocity     (out_rsp.velocity)
  );

endmodule

/* design/wgs_ram.sv */
// wgs_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module wgs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

/* design/wgs_ctrl.sv */
// wgs_ctrl: request sequencer, clearing pass, sweep and drain counting
// depends on wgs_pkg
`timescale 1ns / 1ps

module wgs_ctrl
  import wgs_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT,
  localparam int JW    = $clog2(CELLS + GRID_WIDTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  input  wgs_sts_t         sts,
  output wgs_cmd_t         cmd,
  output logic [JW-1:0]    cnt
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_RD_ISSUE = 3'd2;
  localparam logic [2:0] S_RD_WAIT  = 3'd3;
  localparam logic [2:0] S_STEP     = 3'd4;
  localparam logic [2:0] S_DRAIN    = 3'd5;

  localparam int DRAIN_LEN = 8;

  logic [2:0]    state_r, state_nxt;
  logic [JW-1:0] cnt_r, cnt_nxt;

  assign cnt      = cnt_r;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.ctr_ok   = (cnt_r >= JW'(GRID_WIDTH));
    cmd.interior = (cnt_r >= JW'(2 * GRID_WIDTH)) && (cnt_r < JW'(CELLS));
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == JW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            CMD_WRITE: cmd.host_wr = 1'b1;
            CMD_STEP: begin
              cnt_nxt   = '0;
              state_nxt = S_STEP;
            end
            CMD_READ: begin
              cmd.rd_latch = 1'b1;
              state_nxt    = S_RD_ISSUE;
            end
            default: ;
          endcase
        end
      end
      S_RD_ISSUE: state_nxt = S_RD_WAIT;
      S_RD_WAIT: begin
        if (sts.out_free) begin
          cmd.rd_load = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_STEP: begin
        cmd.strm = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == JW'(CELLS + GRID_WIDTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == JW'(DRAIN_LEN - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* design/wgs_dp.sv */
// wgs_dp: grid memories, two row-delay line buffers, stencil pipeline, result register
// depends on wgs_pkg and wgs_ram
`timescale 1ns / 1ps

module wgs_dp
  import wgs_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT,
  localparam int JW    = $clog2(CELLS + GRID_WIDTH),
  localparam int AW    = $clog2(CELLS),
  localparam int LD    = GRID_WIDTH - 2,
  localparam int LAW   = $clog2(LD)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wgs_cmd_t              cmd,
  input  logic [JW-1:0]         cnt,
  output wgs_sts_t              sts,
  input  logic [COORD_W-1:0]    in_cell_x,
  input  logic [COORD_W-1:0]    in_cell_y,
  input  logic signed [Q_W-1:0] in_write_value,
  input  logic                  cfg_we,
  input  logic [SPD_W-1:0]      cfg_wdata,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic signed [Q_W-1:0] out_displacement,
  output logic signed [Q_W-1:0] out_velocity
);

  function automatic logic signed [Q_W-1:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -28'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[Q_W-1:0];
    end
  endfunction

  // config
  logic [SPD_W-1:0] spd_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_r <= SPD_RESET;
    end else if (cfg_we) begin
      spd_r <= (cfg_wdata > SPD_ONE) ? SPD_ONE : cfg_wdata;
    end
  end

  // host address
  logic          in_grid;
  logic [AW-1:0] haddr;
  logic [AW-1:0] addr_r;
  logic          in_grid_r;
  assign in_grid = (int'(in_cell_x) < GRID_WIDTH) && (int'(in_cell_y) < GRID_HEIGHT);
  assign haddr   = AW'(in_cell_y) * AW'(GRID_WIDTH) + AW'(in_cell_x);

  always_ff @(posedge clk) begin
    if (cmd.rd_latch) begin
      addr_r    <= haddr;
      in_grid_r <= in_grid;
    end
  end

  // sweep addresses
  logic [JW-1:0] ctr_j;
  logic [AW-1:0] d_raddr, v_raddr;
  assign ctr_j   = cnt - JW'(GRID_WIDTH);
  assign d_raddr = (cmd.strm && cnt < JW'(CELLS)) ? cnt[AW-1:0] :
                   (cmd.strm ? '0 : addr_r);
  assign v_raddr = (cmd.strm && cmd.ctr_ok) ? ctr_j[AW-1:0] :
                   (cmd.strm ? '0 : addr_r);

  // stage s: ram read in flight
  logic          s_vld_r, s_ok_r, s_int_r;
  logic [AW-1:0] s_i_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= cmd.strm;
    end
    s_ok_r  <= cmd.ctr_ok;
    s_int_r <= cmd.interior;
    s_i_r   <= ctr_j[AW-1:0];
  end

  // memories and write ports
  logic [Q_W-1:0] d_rdata, v_rdata;
  logic           d_we, v_we;
  logic [AW-1:0]  d_waddr, v_waddr;
  logic [Q_W-1:0] d_wdata, v_wdata;

  logic                  p4_vld_r, p4_int_r;
  logic [AW-1:0]         p4_i_r;
  logic signed [Q_W-1:0] p4_d_r, p4_v_r;

  always_comb begin
    d_we    = 1'b0;
    d_waddr = haddr;
    d_wdata = in_write_value;
    v_we    = 1'b0;
    v_waddr = p4_i_r;
    v_wdata = p4_v_r;
    if (cmd.clr) begin
      d_we    = 1'b1;
      d_waddr = cnt[AW-1:0];
      d_wdata = '0;
      v_we    = 1'b1;
      v_waddr = cnt[AW-1:0];
      v_wdata = '0;
    end else if (p4_vld_r) begin
      d_we    = 1'b1;
      d_waddr = p4_i_r;
      d_wdata = p4_int_r ? p4_d_r : '0;  // border rows go to zero
      v_we    = p4_int_r;
    end else if (cmd.host_wr && in_grid) begin
      d_we = 1'b1;
    end
  end

  wgs_ram #(.WIDTH(Q_W), .DEPTH(CELLS)) u_disp (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  wgs_ram #(.WIDTH(Q_W), .DEPTH(CELLS)) u_vel (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  // row delay lines: each one row minus two, plus the read register
  logic [LAW-1:0] lptr_r;
  logic [Q_W-1:0] o1, o2;
  logic [Q_W-1:0] a_r, b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lptr_r <= '0;
    end else if (s_vld_r) begin
      lptr_r <= (lptr_r == LAW'(LD - 1)) ? '0 : lptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_vld_r) begin
      a_r <= o1;
      b_r <= a_r;
    end
  end

  wgs_ram #(.WIDTH(Q_W), .DEPTH(LD)) u_line1 (
    .clk(clk), .we(s_vld_r), .waddr(lptr_r), .wdata(d_rdata),
    .raddr(lptr_r), .rdata(o1)
  );

  wgs_ram #(.WIDTH(Q_W), .DEPTH(LD)) u_line2 (
    .clk(clk), .we(s_vld_r), .waddr(lptr_r), .wdata(b_r),
    .raddr(lptr_r), .rdata(o2)
  );

  // p0: laplacian of old displacements
  logic signed [Q_W-1:0] t_up, t_lf, t_ct, t_rt, t_dn;
  logic signed [26:0]    lap;
  assign t_up = o2;
  assign t_lf = b_r;
  assign t_ct = a_r;
  assign t_rt = o1;
  assign t_dn = d_rdata;
  assign lap  = 27'(t_up) + 27'(t_lf) + 27'(t_rt) + 27'(t_dn) - (27'(t_ct) <<< 2);

  logic                  p1_vld_r, p1_int_r;
  logic [AW-1:0]         p1_i_r;
  logic signed [26:0]    p1_lap_r;
  logic signed [Q_W-1:0] p1_d_r, p1_v_r;

  logic                  p2_vld_r, p2_int_r;
  logic [AW-1:0]         p2_i_r;
  logic signed [Q_W-1:0] p2_d_r, p2_v_r;

  logic                  p3_vld_r, p3_int_r;
  logic [AW-1:0]         p3_i_r;
  logic signed [Q_W-1:0] p3_d_r, p3_v_r;
  logic signed [37:0]    p3_p_r;

  logic signed [38:0]    rnd;
  logic signed [26:0]    q;
  assign rnd = 39'(p3_p_r) + 39'sd2048;
  assign q   = rnd[38:12];  // floor divide by 4096 after half-up bias

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= s_vld_r && s_ok_r;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
    end
    p1_int_r <= s_int_r;
    p1_i_r   <= s_i_r;
    p1_lap_r <= lap;
    p1_d_r   <= t_ct;
    p1_v_r   <= v_rdata;

    p2_int_r <= p1_int_r;
    p2_i_r   <= p1_i_r;
    p2_d_r   <= p1_d_r;
    p2_v_r   <= sat24(28'(p1_v_r) + 28'(p1_lap_r));

    p3_int_r <= p2_int_r;
    p3_i_r   <= p2_i_r;
    p3_d_r   <= p2_d_r;
    p3_v_r   <= p2_v_r;
    p3_p_r   <= 38'(p2_v_r) * 38'($signed({1'b0, spd_r}));

    p4_int_r <= p3_int_r;
    p4_i_r   <= p3_i_r;
    p4_v_r   <= p3_v_r;
    p4_d_r   <= sat24(28'(p3_d_r) + 28'(q));
  end

  // result register
  logic                  out_valid_r;
  logic signed [Q_W-1:0] out_disp_r, out_vel_r;

  assign sts.out_free     = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_displacement = out_disp_r;
  assign out_velocity     = out_vel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rd_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.rd_load) begin
      out_disp_r <= in_grid_r ? d_rdata : '0;
      out_vel_r  <= in_grid_r ? v_rdata : '0;
    end
  end

endmodule

/* tb/wgs_step_checker.sv */
// wgs_step_checker: watches the request, result and config ports of the wave grid
// stepper, keeps its own copy of both grids and checks every read result
// depends on wgs_pkg and wgs_ifs
`timescale 1ns / 1ps

module wgs_step_checker
  import wgs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  wgs_in_if                in_mon,
  wgs_out_if               out_mon,
  input  logic             cfg_we,
  input  logic [SPD_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               reads_pending
);

  localparam int W     = GRID_WIDTH_DEF;
  localparam int H     = GRID_HEIGHT_DEF;
  localparam int CELLS = W * H;

  typedef struct packed {
    logic signed [Q_W-1:0] disp;
    logic signed [Q_W-1:0] vel;
  } cell_rd_t;

  logic signed [Q_W-1:0] disp_grid [CELLS];
  logic signed [Q_W-1:0] vel_grid  [CELLS];
  logic signed [Q_W-1:0] prev_disp [CELLS];
  logic [SPD_W-1:0]      speed_sq;
  cell_rd_t              read_queue [$];

  function automatic logic signed [Q_W-1:0] clamp_q(longint v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[Q_W-1:0];
  endfunction

  // jacobi pass: every neighbor comes from the snapshot taken before the sweep
  task automatic advance_grid();
    longint s, lap, v, p;
    int idx;
    s = (speed_sq > SPD_ONE) ? 4096 : longint'(speed_sq);
    for (int k = 0; k < CELLS; k++) prev_disp[k] = disp_grid[k];
    for (int r = 1; r < H - 1; r++) begin
      for (int c = 0; c < W; c++) begin
        idx = r * W + c;
        lap = longint'(prev_disp[idx-W]) + longint'(prev_disp[idx-1])
            + longint'(prev_disp[idx+1]) + longint'(prev_disp[idx+W])
            - 4 * longint'(prev_disp[idx]);
        v = longint'(clamp_q(longint'(vel_grid[idx]) + lap));
        vel_grid[idx] = v[Q_W-1:0];
        p = v * s;
        disp_grid[idx] = clamp_q(longint'(prev_disp[idx]) + ((p + 2048) >>> 12));
      end
    end
    for (int c = 0; c < W; c++) begin
      disp_grid[c] = '0;
      disp_grid[(H-1)*W + c] = '0;
    end
  endtask

  task automatic report_mismatch(string what, logic [Q_W-1:0] got, logic [Q_W-1:0] want);
    $display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    speed_sq   = SPD_RESET;
    for (int k = 0; k < CELLS; k++) begin
      disp_grid[k] = '0;
      vel_grid[k]  = '0;
    end
  end

  assign reads_pending = read_queue.size();

  always @(posedge clk) begin
    cell_rd_t want;
    int idx;
    if (rst_n) begin
      if (cfg_we) speed_sq <= cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        if (read_queue.size() == 0) begin
          report_mismatch("result with no read request waiting", out_mon.displacement, '0);
        end else begin
          want = read_queue.pop_front();
          if (out_mon.displacement !== want.disp)
            report_mismatch("displacement", out_mon.displacement, want.disp);
          if (out_mon.velocity !== want.vel)
            report_mismatch("velocity", out_mon.velocity, want.vel);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        idx = int'(in_mon.cell_y) * W + int'(in_mon.cell_x);
        case (in_mon.command)
          CMD_WRITE: if (in_mon.cell_x < W && in_mon.cell_y < H)
            disp_grid[idx] = in_mon.write_value;
          CMD_STEP: advance_grid();
          CMD_READ: begin
            if (in_mon.cell_x < W && in_mon.cell_y < H)
              read_queue.push_back('{disp: disp_grid[idx], vel: vel_grid[idx]});
            else
              read_queue.push_back('{disp: '0, vel: '0});
          end
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/tb_top.sv */
// tb_top: stimulus and verdict for the wave grid stencil step unit
// depends on wgs_pkg, wgs_ifs, the design and wgs_step_checker
`timescale 1ns / 1ps

module tb_top;
  import wgs_pkg::*;

  localparam int W          = GRID_WIDTH_DEF;
  localparam int H          = GRID_HEIGHT_DEF;
  localparam int STEP_DRAIN = W * H + W + 16;
  localparam int LIMIT      = 4000000;
  localparam int MAX_STEPS  = 5;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [SPD_W-1:0] cfg_wdata;
  int               fail_count;
  int               reads_pending;
  int               cycles;
  int               idle_pct;
  int               stall_pct;
  int               n_items, n_reads, n_steps, n_cfg;
  bit               step_in_flight;

  wgs_in_if  in_req ();
  wgs_out_if out_rsp ();

  wave_grid_stencil_step_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req.sink),
    .out_rsp   (out_rsp.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  wgs_step_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_req),
    .out_mon       (out_rsp),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .reads_pending (reads_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  // sends one request; called just after the clock rises, returns once the request is accepted
  task automatic send_req(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] x,
                          logic [COORD_W-1:0] y, logic [Q_W-1:0] val);
    int gap;
    gap = 0;
    // each cycle idles with probability idle_pct
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.command     <= cmd;
    in_req.cell_x      <= x;
    in_req.cell_y      <= y;
    in_req.write_value <= val;
    do @(posedge clk); while (!in_req.ready);
    n_items++;
    if (cmd == CMD_READ) n_reads++;
    if (cmd == CMD_STEP) begin
      n_steps++;
      step_in_flight = 1'b1;
    end
  endtask

  // waits until the block is idle (no read outstanding and any step sweep finished), then writes the speed config
  task automatic drain_and_config(logic [SPD_W-1:0] spd);
    in_req.valid <= 1'b0;
    do @(posedge clk); while (reads_pending != 0);
    if (step_in_flight) repeat (STEP_DRAIN) @(posedge clk);
    step_in_flight = 1'b0;
    cfg_we    <= 1'b1;
    cfg_wdata <= spd;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  // coordinates biased toward grid corners and row ends where wrapping happens
  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(1) == 0) return COORD_W'($urandom_range(255));
    return ($urandom_range(1) == 0) ? COORD_W'($urandom_range(3))
                                    : COORD_W'($urandom_range(255, 252));
  endfunction

  initial begin
    int pick;
    logic [Q_W-1:0] val;
    cycles = 0; idle_pct = 0; stall_pct = 0;
    n_items = 0; n_reads = 0; n_steps = 0; n_cfg = 0;
    step_in_flight = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_req.valid = 1'b0;
    in_req.command = CMD_WRITE;
    in_req.cell_x = '0;
    in_req.cell_y = '0;
    in_req.write_value = '0;
    out_rsp.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, saturating stencil, wrap at row ends, unused command
    drain_and_config(13'd2048);
    send_req(CMD_WRITE, 8'd0, 8'd0, 24'h7fffff);
    send_req(CMD_WRITE, 8'd255, 8'd255, 24'h800000);
    send_req(CMD_READ, 8'd0, 8'd0, '0);
    send_req(CMD_READ, 8'd255, 8'd255, '0);
    send_req(CMD_WRITE, 8'd10, 8'd10, 24'h800000);
    send_req(CMD_WRITE, 8'd9, 8'd10, 24'h7fffff);
    send_req(CMD_WRITE, 8'd11, 8'd10, 24'h7fffff);
    send_req(CMD_WRITE, 8'd10, 8'd9, 24'h7fffff);
    send_req(CMD_WRITE, 8'd10, 8'd11, 24'h7fffff);
    send_req(CMD_WRITE, 8'd255, 8'd1, 24'h001000);
    send_req(CMD_WRITE, 8'd0, 8'd2, 24'hfff000);
    send_req(CMD_UNUSED, 8'd10, 8'd10, 24'h123456);
    send_req(CMD_STEP, 8'd0, 8'd0, '0);
    send_req(CMD_READ, 8'd10, 8'd10, '0);
    send_req(CMD_READ, 8'd9, 8'd10, '0);
    send_req(CMD_READ, 8'd0, 8'd0, '0);
    send_req(CMD_READ, 8'd255, 8'd1, '0);
    send_req(CMD_READ, 8'd0, 8'd2, '0);
    send_req(CMD_READ, 8'd0, 8'd1, '0);
    send_req(CMD_READ, 8'd255, 8'd255, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  drain_and_config(13'd0);    end
        1: begin idle_pct = 49; stall_pct = 0;  drain_and_config(SPD_ONE);  end
        2: begin idle_pct = 0;  stall_pct = 49; drain_and_config(13'd8191); end
        default: begin
          idle_pct = 36; stall_pct = 36;
          drain_and_config(SPD_W'($urandom_range(8191)));
        end
      endcase
      for (int k = 0; k < 20; k++) begin
        if (ph == 1 && k == 12) begin
          // hold off until every read result is back
          in_req.valid <= 1'b0;
          do @(posedge clk); while (reads_pending != 0);
        end
        pick = $urandom_range(99);
        val  = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 24'h7fffff : 24'h800000)
                                        : Q_W'($urandom());
        if (pick < 46)
          send_req(CMD_WRITE, pick_coord(), pick_coord(), val);
        else if (pick < 92)
          send_req(CMD_READ, pick_coord(), pick_coord(), val);
        else if (pick < 96 && n_steps < MAX_STEPS)
          send_req(CMD_STEP, pick_coord(), pick_coord(), val);
        else
          send_req(CMD_UNUSED, pick_coord(), pick_coord(), val);
      end
    end

    in_req.valid <= 1'b0;
    do @(posedge clk); while (reads_pending != 0);
    repeat (20) @(posedge clk);
    $display("covered %0d requests (%0d reads, %0d steps) over %0d speed settings",
             n_items, n_reads, n_steps, n_cfg);
    $display("idle and stall phases run, %0d mismatches seen", fail_count);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
